// File: hw/rtl/assert_macros.svh
// assertion helper macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on the rising clock edge, quiet during reset
`define AEC_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the rising clock edge, quiet during reset
`define AEC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/aec_pkg.sv
// types, constants and helper functions for the easing curve block
`default_nettype none
package aec_pkg;

   // field widths
   localparam int FRAC_BITS  = 16;
   localparam int ALPHA_W    = FRAC_BITS + 2;
   localparam int PROG_W     = FRAC_BITS + 1;
   localparam int ANG_W      = FRAC_BITS + 2;
   localparam int DELTA_W    = 20;
   localparam int DUR_W      = 32;
   localparam int MODE_W     = 4;
   localparam int CP_W       = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // internal signed working width for Q.FRAC_BITS values
   localparam int WORK_W = 24;

   // serial arithmetic units
   localparam int MUL_W     = 32;
   localparam int MUL_DIG   = 4;
   localparam int MOP_W     = MUL_W + 1;
   localparam int DIV_NUM_W = DUR_W + FRAC_BITS;
   localparam int DIV_DEN_W = 32;

   localparam int BEZIER_MAX_STEPS_DEF = 16;

   // fixed point constants
   localparam logic signed [WORK_W-1:0] ONE_Q = WORK_W'(64'd1 << FRAC_BITS);
   localparam logic [31:0] Q30_C       = 32'd1 << 30;
   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [31:0] BACK_C_Q30  = 32'd1827057613;
   localparam logic [31:0] TOL_Q30     = 32'd1073742;
   localparam logic signed [WORK_W-1:0] BACK_K =
      WORK_W'((64'(BACK_C_Q30) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
   localparam logic signed [WORK_W-1:0] BACK_K1 = BACK_K + ONE_Q;
   localparam logic signed [WORK_W-1:0] BEZ_TOL =
      WORK_W'((64'(TOL_Q30) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
   localparam logic signed [WORK_W-1:0] ALPHA_MAX = WORK_W'((64'd1 << (ALPHA_W - 1)) - 1);
   localparam logic signed [WORK_W-1:0] ALPHA_MIN = -ALPHA_MAX - WORK_W'(1);
   localparam logic [PROG_W-1:0] PROG_MAX = PROG_W'(64'd1 << FRAC_BITS);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DURATION  = 3'd0,
      CSR_MODE      = 3'd1,
      CSR_BEZ_X1    = 3'd2,
      CSR_BEZ_Y1    = 3'd3,
      CSR_BEZ_X2    = 3'd4,
      CSR_BEZ_Y2    = 3'd5
   } csr_index_type;

   // curve codes
   typedef enum logic [MODE_W-1:0] {
      CURVE_LINEAR      = 4'd0,
      CURVE_REVERSE     = 4'd1,
      CURVE_IN_QUAD     = 4'd2,
      CURVE_OUT_QUAD    = 4'd3,
      CURVE_IN_CUBIC    = 4'd4,
      CURVE_OUT_CUBIC   = 4'd5,
      CURVE_SMOOTH      = 4'd6,
      CURVE_IN_SINE     = 4'd7,
      CURVE_OUT_SINE    = 4'd8,
      CURVE_IN_OUT_SINE = 4'd9,
      CURVE_BOUNCE      = 4'd10,
      CURVE_SIN         = 4'd11,
      CURVE_OUT_BACK    = 4'd12,
      CURVE_BEZIER      = 4'd13
   } curve_type;

   typedef struct packed {
      logic [DELTA_W-1:0] delta_us;
      logic               restart;
   } req_type;

   typedef struct packed {
      logic signed [ALPHA_W-1:0] alpha;
      logic [PROG_W-1:0]         progress_q16;
   } rsp_type;

   typedef struct packed {
      logic [DUR_W-1:0]       duration_us;
      logic [MODE_W-1:0]      curve_mode;
      logic signed [CP_W-1:0] bezier_x1;
      logic signed [CP_W-1:0] bezier_y1;
      logic signed [CP_W-1:0] bezier_x2;
      logic signed [CP_W-1:0] bezier_y2;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   // taylor divisors for the horner sine steps
   function automatic logic [6:0] taylor_div(input logic [2:0] idx);
      logic [6:0] d;
      case (idx)
         3'd0:    d = 7'd110;
         3'd1:    d = 7'd72;
         3'd2:    d = 7'd42;
         3'd3:    d = 7'd20;
         default: d = 7'd6;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/aec_mul.sv
// digit-serial unsigned multiplier, one 4-bit digit of the multiplier per cycle
`default_nettype none
module aec_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire aec_pkg::mul_req_type          req,
   output logic                               done,
   output logic [2*aec_pkg::MUL_W-1:0]        prod
);

   localparam int STEPS = aec_pkg::MUL_W / aec_pkg::MUL_DIG;
   localparam int CNT_W = $clog2(STEPS);
   localparam int SUM_W = aec_pkg::MUL_W + aec_pkg::MUL_DIG;

   logic [aec_pkg::MUL_W-1:0] a_ff;
   logic [aec_pkg::MUL_W-1:0] hi_ff;
   logic [aec_pkg::MUL_W-1:0] lo_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      busy_ff;
   logic                      done_ff;
   logic [SUM_W-1:0]          sum;

   // partial product of one digit added to the running high word
   assign sum = SUM_W'(hi_ff) + SUM_W'(a_ff) * SUM_W'(lo_ff[aec_pkg::MUL_DIG-1:0]);

   // shift-add sequencing
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            a_ff    <= req.a;
            lo_ff   <= req.b;
            hi_ff   <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            hi_ff  <= sum[SUM_W-1:aec_pkg::MUL_DIG];
            lo_ff  <= {sum[aec_pkg::MUL_DIG-1:0], lo_ff[aec_pkg::MUL_W-1:aec_pkg::MUL_DIG]};
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule
`default_nettype wire

// File: hw/rtl/aec_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module aec_div (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire aec_pkg::div_req_type         req,
   output logic                              done,
   output logic [aec_pkg::DIV_NUM_W-1:0]     quot
);

   localparam int NW    = aec_pkg::DIV_NUM_W;
   localparam int DW    = aec_pkg::DIV_DEN_W;
   localparam int CNT_W = $clog2(NW);

   logic [NW-1:0]    num_ff;
   logic [DW-1:0]    den_ff;
   logic [DW-1:0]    rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DW:0]      trial;
   logic [DW:0]      diff;
   logic             ge;

   // trial subtract of the divisor from the shifted remainder
   assign trial = {rem_ff, num_ff[NW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign ge    = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            num_ff  <= req.num;
            den_ff  <= req.den;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DW-1:0] : trial[DW-1:0];
            num_ff <= {num_ff[NW-2:0], ge};
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule
`default_nettype wire

// File: hw/rtl/aec_seq.sv
// sequencer: progress divide and curve evaluation on the shared serial units
`default_nettype none
module aec_seq #(
   parameter int BEZIER_MAX_STEPS = aec_pkg::BEZIER_MAX_STEPS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [aec_pkg::DUR_W-1:0] elapsed,
   input  wire aec_pkg::cfg_type          cfg,
   input  wire logic                      out_free,
   output logic                           done,
   output aec_pkg::rsp_type               result
);

   localparam int F     = aec_pkg::FRAC_BITS;
   localparam int W     = aec_pkg::WORK_W;
   localparam int OW    = aec_pkg::MOP_W;
   localparam int STP_W = $clog2(BEZIER_MAX_STEPS + 1);

   typedef enum logic [5:0] {
      S_IDLE, S_PROG, S_EASE, S_MUL_WAIT, S_DIV_WAIT,
      S_M3, S_M4, S_M5A, S_M5B, S_M6, S_M12A, S_M12B, S_M12C, S_RES_MQ,
      S_SIN_A, S_SIN_X, S_SIN_X2, S_SIN_LOOP, S_SIN_DIV, S_SIN_T, S_SIN_M,
      S_SIN_S, S_SIN_POST,
      S_B0, S_B1, S_B2, S_B3, S_B4, S_B5, S_B6L, S_B6, S_B7, S_BCHK,
      S_FIN
   } state_type;

   typedef enum logic [1:0] {
      POST_ID, POST_ONE_MINUS, POST_HALF
   } post_type;

   state_type   state_ff, ret_ff;
   post_type    post_ff;
   logic        done_ff;
   logic        mul_go_ff;
   logic        div_go_ff;
   logic signed [OW-1:0] op_a_ff, op_b_ff;
   logic [aec_pkg::DIV_NUM_W-1:0] div_num_ff;
   logic [aec_pkg::DIV_DEN_W-1:0] div_den_ff;

   logic [2*aec_pkg::MUL_W-1:0]   prod_ff;
   logic [aec_pkg::DIV_NUM_W-1:0] quot_ff;
   logic signed [W-1:0] mq_ff, p_ff, res_ff, tmp_ff;
   logic signed [W-1:0] t_ff, lo_ff, hi_ff, s_ff, t2_ff, w1_ff, w2_ff, w3_ff, x_ff, v_ff;
   logic [aec_pkg::ANG_W-1:0] ang_ff;
   logic [1:0]  quad_ff;
   logic [31:0] sx_ff, sx2_ff, st_ff;
   logic [2:0]  idx_ff;
   logic [STP_W-1:0] step_ff;
   logic        yph_ff;

   aec_pkg::mul_req_type mul_req;
   aec_pkg::div_req_type div_req;
   logic                 mul_done, div_done;
   logic [2*aec_pkg::MUL_W-1:0]   mul_prod;
   logic [aec_pkg::DIV_NUM_W-1:0] div_quot;

   logic [aec_pkg::MUL_W-1:0] mag_a, mag_b;
   logic                      prod_neg;
   logic [2*aec_pkg::MUL_W-1:0] rnd;
   logic signed [W-1:0]       mq_mag, mq_val;
   logic [aec_pkg::DUR_W-1:0] clamped;
   logic [F:0]                fold_r;
   logic [31:0]               sin_s, sin_cap;
   logic [31:0]               sin_rnd;
   logic signed [W-1:0]       sin_v;
   logic signed [W-1:0]       bz_d, bz_ad, bz_x, bz_sum;
   logic                      bz_stop, bz_up;
   logic signed [W-1:0]       ctl_a, ctl_b, k_q, mq3;

   // shared serial units
   aec_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   aec_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   // multiplier operands as sign and magnitude
   assign mag_a    = op_a_ff[OW-1] ? aec_pkg::MUL_W'(-op_a_ff) : op_a_ff[OW-2:0];
   assign mag_b    = op_b_ff[OW-1] ? aec_pkg::MUL_W'(-op_b_ff) : op_b_ff[OW-2:0];
   assign prod_neg = op_a_ff[OW-1] ^ op_b_ff[OW-1];
   assign mul_req  = '{start: mul_go_ff, a: mag_a, b: mag_b};
   assign div_req  = '{start: div_go_ff, num: div_num_ff, den: div_den_ff};

   // fixed point product rounded half away from zero
   assign rnd    = mul_prod + (64'd1 << (F - 1));
   assign mq_mag = rnd[F+W-1:F];
   assign mq_val = prod_neg ? -mq_mag : mq_mag;
   assign mq3    = mq_ff + (mq_ff <<< 1);

   // progress numerator clamp
   assign clamped = (elapsed < cfg.duration_us) ? elapsed : cfg.duration_us;

   // sine: fold into the first quarter wave
   assign fold_r = quad_ff[0] ? ((F+1)'(1) << F) - (F+1)'(ang_ff[F-1:0])
                              : (F+1)'(ang_ff[F-1:0]);
   // sine: cap at one and round to the output format
   assign sin_s   = prod_ff[61:30];
   assign sin_cap = (sin_s > aec_pkg::Q30_C) ? aec_pkg::Q30_C : sin_s;
   assign sin_rnd = (sin_cap + (32'd1 << (29 - F))) >> (30 - F);
   assign sin_v   = quad_ff[1] ? -W'(sin_rnd) : W'(sin_rnd);

   // bezier search test
   assign bz_d    = p_ff - x_ff;
   assign bz_ad   = bz_d[W-1] ? -bz_d : bz_d;
   assign bz_stop = (bz_ad <= aec_pkg::BEZ_TOL) || (step_ff == STP_W'(BEZIER_MAX_STEPS));
   assign bz_up   = p_ff > x_ff;
   assign bz_sum  = tmp_ff + mq_ff + w3_ff;
   assign bz_x    = bz_up ? t_ff : lo_ff;
   assign ctl_a   = yph_ff ? W'(cfg.bezier_y1) : W'(cfg.bezier_x1);
   assign ctl_b   = yph_ff ? W'(cfg.bezier_y2) : W'(cfg.bezier_x2);
   assign k_q     = mq_ff + aec_pkg::BACK_K;

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         done_ff   <= 1'b0;
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
      end else begin
         done_ff   <= 1'b0;
         mul_go_ff <= 1'b0;
         div_go_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  if (cfg.duration_us == '0) begin
                     p_ff     <= aec_pkg::ONE_Q;
                     state_ff <= S_EASE;
                  end else begin
                     div_num_ff <= aec_pkg::DIV_NUM_W'(clamped) << F;
                     div_den_ff <= cfg.duration_us;
                     div_go_ff  <= 1'b1;
                     ret_ff     <= S_PROG;
                     state_ff   <= S_DIV_WAIT;
                  end
               end
            end
            S_PROG: begin
               p_ff     <= W'(quot_ff[aec_pkg::PROG_W-1:0]);
               state_ff <= S_EASE;
            end
            S_MUL_WAIT: begin
               if (mul_done) begin
                  prod_ff  <= mul_prod;
                  mq_ff    <= mq_val;
                  state_ff <= ret_ff;
               end
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  quot_ff  <= div_quot;
                  state_ff <= ret_ff;
               end
            end
            // curve dispatch
            S_EASE: begin
               case (cfg.curve_mode)
                  aec_pkg::CURVE_REVERSE: begin
                     res_ff   <= aec_pkg::ONE_Q - p_ff;
                     state_ff <= S_FIN;
                  end
                  aec_pkg::CURVE_IN_QUAD, aec_pkg::CURVE_IN_CUBIC,
                  aec_pkg::CURVE_SMOOTH: begin
                     op_a_ff   <= OW'(p_ff);
                     op_b_ff   <= OW'(p_ff);
                     mul_go_ff <= 1'b1;
                     ret_ff    <= (cfg.curve_mode == aec_pkg::CURVE_IN_QUAD) ? S_RES_MQ :
                                  (cfg.curve_mode == aec_pkg::CURVE_IN_CUBIC) ? S_M4 : S_M6;
                     state_ff  <= S_MUL_WAIT;
                  end
                  aec_pkg::CURVE_OUT_QUAD: begin
                     op_a_ff   <= OW'(aec_pkg::ONE_Q - p_ff);
                     op_b_ff   <= OW'(aec_pkg::ONE_Q - p_ff);
                     mul_go_ff <= 1'b1;
                     ret_ff    <= S_M3;
                     state_ff  <= S_MUL_WAIT;
                  end
                  aec_pkg::CURVE_OUT_CUBIC, aec_pkg::CURVE_OUT_BACK: begin
                     tmp_ff    <= p_ff - aec_pkg::ONE_Q;
                     op_a_ff   <= OW'(p_ff - aec_pkg::ONE_Q);
                     op_b_ff   <= OW'(p_ff - aec_pkg::ONE_Q);
                     mul_go_ff <= 1'b1;
                     ret_ff    <= (cfg.curve_mode == aec_pkg::CURVE_OUT_BACK) ? S_M12A : S_M5A;
                     state_ff  <= S_MUL_WAIT;
                  end
                  aec_pkg::CURVE_IN_SINE: begin
                     ang_ff   <= aec_pkg::ANG_W'(p_ff + aec_pkg::ONE_Q);
                     post_ff  <= POST_ONE_MINUS;
                     state_ff <= S_SIN_A;
                  end
                  aec_pkg::CURVE_OUT_SINE: begin
                     ang_ff   <= aec_pkg::ANG_W'(p_ff);
                     post_ff  <= POST_ID;
                     state_ff <= S_SIN_A;
                  end
                  aec_pkg::CURVE_IN_OUT_SINE: begin
                     ang_ff   <= aec_pkg::ANG_W'((p_ff <<< 1) + aec_pkg::ONE_Q);
                     post_ff  <= POST_HALF;
                     state_ff <= S_SIN_A;
                  end
                  aec_pkg::CURVE_BOUNCE: begin
                     ang_ff   <= aec_pkg::ANG_W'(p_ff <<< 1);
                     post_ff  <= POST_ID;
                     state_ff <= S_SIN_A;
                  end
                  aec_pkg::CURVE_SIN: begin
                     ang_ff   <= aec_pkg::ANG_W'((p_ff <<< 2) + aec_pkg::ONE_Q);
                     post_ff  <= POST_HALF;
                     state_ff <= S_SIN_A;
                  end
                  aec_pkg::CURVE_BEZIER: begin
                     if (p_ff <= '0 || p_ff >= aec_pkg::ONE_Q) begin
                        res_ff   <= p_ff;
                        state_ff <= S_FIN;
                     end else begin
                        t_ff     <= aec_pkg::ONE_Q >>> 1;
                        lo_ff    <= '0;
                        hi_ff    <= aec_pkg::ONE_Q;
                        step_ff  <= '0;
                        yph_ff   <= 1'b0;
                        state_ff <= S_B0;
                     end
                  end
                  default: begin
                     res_ff   <= p_ff;
                     state_ff <= S_FIN;
                  end
               endcase
            end
            // polynomial curves
            S_RES_MQ: begin
               res_ff   <= mq_ff;
               state_ff <= S_FIN;
            end
            S_M3: begin
               res_ff   <= aec_pkg::ONE_Q - mq_ff;
               state_ff <= S_FIN;
            end
            S_M4: begin
               op_a_ff   <= OW'(mq_ff);
               op_b_ff   <= OW'(p_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_RES_MQ;
               state_ff  <= S_MUL_WAIT;
            end
            S_M5A: begin
               op_a_ff   <= OW'(mq_ff);
               op_b_ff   <= OW'(tmp_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_M5B;
               state_ff  <= S_MUL_WAIT;
            end
            S_M5B: begin
               res_ff   <= mq_ff + aec_pkg::ONE_Q;
               state_ff <= S_FIN;
            end
            S_M6: begin
               op_a_ff   <= OW'(mq_ff);
               op_b_ff   <= OW'((aec_pkg::ONE_Q <<< 1) + aec_pkg::ONE_Q - (p_ff <<< 1));
               mul_go_ff <= 1'b1;
               ret_ff    <= S_RES_MQ;
               state_ff  <= S_MUL_WAIT;
            end
            // back overshoot: one + q^2 * (k1 q + k)
            S_M12A: begin
               s_ff      <= mq_ff;
               op_a_ff   <= OW'(aec_pkg::BACK_K1);
               op_b_ff   <= OW'(tmp_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_M12B;
               state_ff  <= S_MUL_WAIT;
            end
            S_M12B: begin
               op_a_ff   <= OW'(s_ff);
               op_b_ff   <= OW'(k_q);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_M12C;
               state_ff  <= S_MUL_WAIT;
            end
            S_M12C: begin
               res_ff   <= aec_pkg::ONE_Q + mq_ff;
               state_ff <= S_FIN;
            end
            // sine: angle to radians, then horner polynomial
            S_SIN_A: begin
               quad_ff   <= ang_ff[F+1:F];
               state_ff  <= S_SIN_X;
               ret_ff    <= S_SIN_X;
            end
            S_SIN_X: begin
               if (ret_ff == S_SIN_X) begin
                  op_a_ff   <= OW'(fold_r);
                  op_b_ff   <= OW'(aec_pkg::HALF_PI_Q30);
                  mul_go_ff <= 1'b1;
                  ret_ff    <= S_SIN_X2;
                  state_ff  <= S_MUL_WAIT;
               end
            end
            S_SIN_X2: begin
               sx_ff     <= prod_ff[F+31:F];
               op_a_ff   <= OW'(prod_ff[F+31:F]);
               op_b_ff   <= OW'(prod_ff[F+31:F]);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_SIN_LOOP;
               state_ff  <= S_MUL_WAIT;
            end
            S_SIN_LOOP: begin
               if (ret_ff == S_SIN_LOOP) begin
                  sx2_ff <= prod_ff[61:30];
                  st_ff  <= aec_pkg::Q30_C;
                  idx_ff <= '0;
                  op_a_ff <= OW'(prod_ff[61:30]);
               end else begin
                  op_a_ff <= OW'(sx2_ff);
               end
               op_b_ff   <= (ret_ff == S_SIN_LOOP) ? OW'(aec_pkg::Q30_C) : OW'(st_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_SIN_DIV;
               state_ff  <= S_MUL_WAIT;
            end
            S_SIN_DIV: begin
               div_num_ff <= aec_pkg::DIV_NUM_W'(prod_ff[61:30]);
               div_den_ff <= aec_pkg::DIV_DEN_W'(aec_pkg::taylor_div(idx_ff));
               div_go_ff  <= 1'b1;
               ret_ff     <= S_SIN_T;
               state_ff   <= S_DIV_WAIT;
            end
            S_SIN_T: begin
               st_ff  <= aec_pkg::Q30_C - quot_ff[31:0];
               idx_ff <= idx_ff + 3'd1;
               ret_ff <= S_SIN_T;
               state_ff <= (idx_ff == 3'd4) ? S_SIN_M : S_SIN_LOOP;
            end
            S_SIN_M: begin
               op_a_ff   <= OW'(sx_ff);
               op_b_ff   <= OW'(st_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_SIN_S;
               state_ff  <= S_MUL_WAIT;
            end
            S_SIN_S: begin
               v_ff     <= sin_v;
               state_ff <= S_SIN_POST;
            end
            S_SIN_POST: begin
               case (post_ff)
                  POST_ONE_MINUS: res_ff <= aec_pkg::ONE_Q - v_ff;
                  POST_HALF:      res_ff <= (aec_pkg::ONE_Q - v_ff) >>> 1;
                  default:        res_ff <= v_ff;
               endcase
               state_ff <= S_FIN;
            end
            // bezier basis weights for the current t
            S_B0: begin
               s_ff      <= aec_pkg::ONE_Q - t_ff;
               op_a_ff   <= OW'(t_ff);
               op_b_ff   <= OW'(t_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_B1;
               state_ff  <= S_MUL_WAIT;
            end
            S_B1: begin
               t2_ff     <= mq_ff;
               op_a_ff   <= OW'(s_ff);
               op_b_ff   <= OW'(s_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_B2;
               state_ff  <= S_MUL_WAIT;
            end
            S_B2: begin
               op_a_ff   <= OW'(mq_ff);
               op_b_ff   <= OW'(t_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_B3;
               state_ff  <= S_MUL_WAIT;
            end
            S_B3: begin
               w1_ff     <= mq3;
               op_a_ff   <= OW'(s_ff);
               op_b_ff   <= OW'(t2_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_B4;
               state_ff  <= S_MUL_WAIT;
            end
            S_B4: begin
               w2_ff     <= mq3;
               op_a_ff   <= OW'(t2_ff);
               op_b_ff   <= OW'(t_ff);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_B5;
               state_ff  <= S_MUL_WAIT;
            end
            S_B5: begin
               w3_ff    <= mq_ff;
               state_ff <= S_B6L;
            end
            // weighted sum with the control points of the current axis
            S_B6L: begin
               op_a_ff   <= OW'(w1_ff);
               op_b_ff   <= OW'(ctl_a);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_B6;
               state_ff  <= S_MUL_WAIT;
            end
            S_B6: begin
               tmp_ff    <= mq_ff;
               op_a_ff   <= OW'(w2_ff);
               op_b_ff   <= OW'(ctl_b);
               mul_go_ff <= 1'b1;
               ret_ff    <= S_B7;
               state_ff  <= S_MUL_WAIT;
            end
            S_B7: begin
               if (yph_ff) begin
                  res_ff   <= bz_sum;
                  state_ff <= S_FIN;
               end else begin
                  x_ff     <= bz_sum;
                  state_ff <= S_BCHK;
               end
            end
            // bisection step or switch to the y axis
            S_BCHK: begin
               if (bz_stop) begin
                  yph_ff   <= 1'b1;
                  state_ff <= S_B6L;
               end else begin
                  if (bz_up) begin
                     lo_ff <= t_ff;
                  end else begin
                     hi_ff <= t_ff;
                  end
                  t_ff     <= (bz_x + (bz_up ? hi_ff : t_ff)) >>> 1;
                  step_ff  <= step_ff + STP_W'(1);
                  state_ff <= S_B0;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // result with alpha saturated to the output range
   assign done = done_ff;
   assign result.alpha = (res_ff > aec_pkg::ALPHA_MAX) ? aec_pkg::ALPHA_MAX[aec_pkg::ALPHA_W-1:0] :
                         (res_ff < aec_pkg::ALPHA_MIN) ? aec_pkg::ALPHA_MIN[aec_pkg::ALPHA_W-1:0] :
                                                        res_ff[aec_pkg::ALPHA_W-1:0];
   assign result.progress_q16 = p_ff[aec_pkg::PROG_W-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/animation_easing_curve.sv
// top level of the easing curve generator: handshakes, registers, elapsed total
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_ready  req_data (delta_us, restart)
//   rsp       out        rsp_valid/rsp_ready  rsp_data (alpha, progress_q16)
//   csr       in         csr_we               csr_index, csr_wdata
//
// one item at a time; the progress divide runs on the 48-bit serial divider
// curve step: linear uses no serial unit, polynomials use the shared multiplier, sine
// uses five serial divides, bezier repeats its multiplies for every search step
// multiply cost is set by the 4-bit-per-cycle shared multiplier
// synchronous reset clears control state, elapsed total and registers
// the next item is taken while a finished item waits in the output register
`default_nettype none
module animation_easing_curve #(
   parameter int BEZIER_MAX_STEPS = aec_pkg::BEZIER_MAX_STEPS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire aec_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output aec_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [aec_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [aec_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   aec_pkg::cfg_type          cfg_ff;
   logic [aec_pkg::DUR_W-1:0] elapsed_ff;
   logic [aec_pkg::DUR_W-1:0] elapsed_in;
   logic [aec_pkg::DUR_W:0]   elapsed_sum;
   logic [aec_pkg::DUR_W-1:0] elapsed_base;
   logic                      busy_ff;
   logic                      start_ff;
   logic                      rsp_valid_ff;
   aec_pkg::rsp_type          rsp_data_ff;
   logic                      accept;
   logic                      seq_done;
   aec_pkg::rsp_type          seq_result;

   assign accept = req_valid && req_ready;

   // saturating elapsed total
   assign elapsed_base = req_data.restart ? '0 : elapsed_ff;
   assign elapsed_sum  = (aec_pkg::DUR_W+1)'(elapsed_base) + (aec_pkg::DUR_W+1)'(req_data.delta_us);
   assign elapsed_in   = elapsed_sum[aec_pkg::DUR_W] ? '1 : elapsed_sum[aec_pkg::DUR_W-1:0];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duration_us <= '0;
         cfg_ff.curve_mode  <= aec_pkg::CURVE_LINEAR;
         cfg_ff.bezier_x1   <= '0;
         cfg_ff.bezier_y1   <= '0;
         cfg_ff.bezier_x2   <= aec_pkg::CP_W'(aec_pkg::ONE_Q);
         cfg_ff.bezier_y2   <= aec_pkg::CP_W'(aec_pkg::ONE_Q);
      end else if (csr_we) begin
         case (csr_index)
            aec_pkg::CSR_DURATION: cfg_ff.duration_us <= csr_wdata;
            aec_pkg::CSR_MODE:     cfg_ff.curve_mode  <= csr_wdata[aec_pkg::MODE_W-1:0];
            aec_pkg::CSR_BEZ_X1:   cfg_ff.bezier_x1   <= csr_wdata[aec_pkg::CP_W-1:0];
            aec_pkg::CSR_BEZ_Y1:   cfg_ff.bezier_y1   <= csr_wdata[aec_pkg::CP_W-1:0];
            aec_pkg::CSR_BEZ_X2:   cfg_ff.bezier_x2   <= csr_wdata[aec_pkg::CP_W-1:0];
            aec_pkg::CSR_BEZ_Y2:   cfg_ff.bezier_y2   <= csr_wdata[aec_pkg::CP_W-1:0];
            default: ;
         endcase
      end
   end

   // item intake and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff   <= '0;
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= accept;
         if (accept) begin
            elapsed_ff <= elapsed_in;
            busy_ff    <= 1'b1;
         end else if (seq_done) begin
            busy_ff <= 1'b0;
         end
         if (seq_done) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= seq_result;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   aec_seq #(
      .BEZIER_MAX_STEPS (BEZIER_MAX_STEPS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .elapsed  (elapsed_ff),
      .cfg      (cfg_ff),
      .out_free (!rsp_valid_ff),
      .done     (seq_done),
      .result   (seq_result)
   );

   assign req_ready = !busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "assert_macros.svh"

   // result is only produced into an empty output register
   `AEC_ASSERT_IMPL(a_done_slot_free, seq_done, !rsp_valid_ff, "result produced over a full slot")
   // an accepted item always starts the sequencer and marks the block busy
   `AEC_ASSERT_NEXT(a_accept_starts, accept, start_ff && busy_ff, "accepted item not started")
   // a result only arrives for an item in flight
   `AEC_ASSERT_IMPL(a_done_busy, seq_done, busy_ff, "result without an item in flight")
   // progress never passes completion
   `AEC_ASSERT_IMPL(a_progress_range, rsp_valid_ff, rsp_data_ff.progress_q16 <= aec_pkg::PROG_MAX, "progress above one")

endmodule
`default_nettype wire

// File: tb/animation_easing_curve_tb.sv
// self-checking testbench for the easing curve generator
`timescale 1ns / 100ps
`default_nettype none
module animation_easing_curve_tb;

   localparam logic [aec_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam longint unsigned TOTAL_MAX = 64'hFFFF_FFFF;
   localparam longint CYCLE_LIMIT = 8_000_000;
   localparam longint Q_ONE = 64'sd1 << aec_pkg::FRAC_BITS;
   localparam longint unsigned Q30_ONE = 64'd1 << 30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   aec_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   aec_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [aec_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [aec_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   animation_easing_curve dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the block state
   longint unsigned elapsed_shadow;
   longint unsigned duration_shadow;
   logic [aec_pkg::MODE_W-1:0] curve_shadow;
   longint ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2;

   aec_pkg::rsp_type eased_q[$];
   int errors = 0;
   longint cycles = 0;
   int rsp_hold = 0;
   bit no_gaps = 0;

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // rounded q product, half away from zero
   function automatic longint qmul(longint a, longint b);
      longint unsigned ma, mb, m;
      bit neg;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      m = (ma * mb + (64'd1 << (aec_pkg::FRAC_BITS - 1))) >> aec_pkg::FRAC_BITS;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint q30_round(longint unsigned v);
      return longint'((v + (64'd1 << (29 - aec_pkg::FRAC_BITS))) >> (30 - aec_pkg::FRAC_BITS));
   endfunction

   // sine of an angle in quarter turns, quarter wave folded, taylor in q30
   function automatic longint sine_turns(longint unsigned ang);
      longint unsigned r, x, x2, t, s, dv;
      int quad;
      longint v;
      quad = int'((ang >> aec_pkg::FRAC_BITS) & 3);
      r = ang & (Q_ONE - 1);
      t = Q30_ONE;
      if (quad & 1) r = Q_ONE - r;
      x = (r * 64'(aec_pkg::HALF_PI_Q30)) >> aec_pkg::FRAC_BITS;
      x2 = (x * x) >> 30;
      for (int i = 0; i < 5; i++) begin
         case (i)
            0: dv = 110;
            1: dv = 72;
            2: dv = 42;
            3: dv = 20;
            default: dv = 6;
         endcase
         t = Q30_ONE - ((x2 * t) >> 30) / dv;
      end
      s = (x * t) >> 30;
      if (s > Q30_ONE) s = Q30_ONE;
      v = q30_round(s);
      return (quad & 2) ? -v : v;
   endfunction

   function automatic longint bezier_at(longint a, longint b, longint t);
      longint s, t2;
      s = Q_ONE - t;
      t2 = qmul(t, t);
      return qmul(qmul(qmul(s, s), t) * 3, a) + qmul(qmul(s, t2) * 3, b) + qmul(t2, t);
   endfunction

   function automatic longint eased_value(longint p);
      longint q, k, lo, hi, t, x, d, tol;
      int steps;
      case (curve_shadow)
         aec_pkg::CURVE_REVERSE:  return Q_ONE - p;
         aec_pkg::CURVE_IN_QUAD:  return qmul(p, p);
         aec_pkg::CURVE_OUT_QUAD: begin
            q = Q_ONE - p;
            return Q_ONE - qmul(q, q);
         end
         aec_pkg::CURVE_IN_CUBIC: return qmul(qmul(p, p), p);
         aec_pkg::CURVE_OUT_CUBIC: begin
            q = p - Q_ONE;
            return qmul(qmul(q, q), q) + Q_ONE;
         end
         aec_pkg::CURVE_SMOOTH:      return qmul(qmul(p, p), 3 * Q_ONE - 2 * p);
         aec_pkg::CURVE_IN_SINE:     return Q_ONE - sine_turns(p + Q_ONE);
         aec_pkg::CURVE_OUT_SINE:    return sine_turns(p);
         aec_pkg::CURVE_IN_OUT_SINE: return (Q_ONE - sine_turns(2 * p + Q_ONE)) / 2;
         aec_pkg::CURVE_BOUNCE:      return sine_turns(2 * p);
         aec_pkg::CURVE_SIN:         return (Q_ONE - sine_turns(4 * p + Q_ONE)) / 2;
         aec_pkg::CURVE_OUT_BACK: begin
            k = q30_round(aec_pkg::BACK_C_Q30);
            q = p - Q_ONE;
            return Q_ONE + qmul(qmul(q, q), qmul(k + Q_ONE, q) + k);
         end
         aec_pkg::CURVE_BEZIER: begin
            lo = 0;
            hi = Q_ONE;
            t = Q_ONE / 2;
            steps = 0;
            tol = q30_round(aec_pkg::TOL_Q30);
            if (p <= 0 || p >= Q_ONE) return p;
            x = bezier_at(ctrl_x1, ctrl_x2, t);
            forever begin
               d = p - x;
               if (d < 0) d = -d;
               if (d <= tol || steps >= aec_pkg::BEZIER_MAX_STEPS_DEF) break;
               if (p > x) lo = t;
               else hi = t;
               t = (lo + hi) / 2;
               x = bezier_at(ctrl_x1, ctrl_x2, t);
               steps++;
            end
            return bezier_at(ctrl_y1, ctrl_y2, t);
         end
         default: return p;
      endcase
   endfunction

   // advance the elapsed total and work out the result of one tick
   function automatic aec_pkg::rsp_type predict_tick(aec_pkg::req_type it);
      longint unsigned sum, clamped;
      longint p, a;
      aec_pkg::rsp_type r;
      if (it.restart) elapsed_shadow = 0;
      sum = elapsed_shadow + it.delta_us;
      elapsed_shadow = sum > TOTAL_MAX ? TOTAL_MAX : sum;
      if (duration_shadow == 0) p = Q_ONE;
      else begin
         clamped = elapsed_shadow < duration_shadow ? elapsed_shadow : duration_shadow;
         p = longint'((clamped << aec_pkg::FRAC_BITS) / duration_shadow);
      end
      a = eased_value(p);
      if (a > aec_pkg::ALPHA_MAX) a = aec_pkg::ALPHA_MAX;
      if (a < aec_pkg::ALPHA_MIN) a = aec_pkg::ALPHA_MIN;
      r.alpha = a[aec_pkg::ALPHA_W-1:0];
      r.progress_q16 = p[aec_pkg::PROG_W-1:0];
      return r;
   endfunction

   function automatic longint sext_cp(logic [aec_pkg::CSR_DATA_W-1:0] v);
      return longint'(signed'(v[aec_pkg::CP_W-1:0]));
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
   endtask

   // register write; the enable stays high for back-to-back writes
   task automatic csr_write(logic [aec_pkg::CSR_IDX_W-1:0] idx,
                            logic [aec_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         aec_pkg::CSR_DURATION: duration_shadow = val;
         aec_pkg::CSR_MODE:     curve_shadow = val[aec_pkg::MODE_W-1:0];
         aec_pkg::CSR_BEZ_X1:   ctrl_x1 = sext_cp(val);
         aec_pkg::CSR_BEZ_Y1:   ctrl_y1 = sext_cp(val);
         aec_pkg::CSR_BEZ_X2:   ctrl_x2 = sext_cp(val);
         aec_pkg::CSR_BEZ_Y2:   ctrl_y2 = sext_cp(val);
         default: ;
      endcase
   endtask

   // sender pauses until every result has come back
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (eased_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] dur, logic [aec_pkg::MODE_W-1:0] mode,
                            logic [aec_pkg::CP_W-1:0] x1, logic [aec_pkg::CP_W-1:0] y1,
                            logic [aec_pkg::CP_W-1:0] x2, logic [aec_pkg::CP_W-1:0] y2);
      drain();
      csr_write(aec_pkg::CSR_DURATION, dur);
      csr_write(aec_pkg::CSR_MODE, {$urandom_range(0, 1) ? 28'($urandom) : 28'd0, mode});
      csr_write(aec_pkg::CSR_BEZ_X1, {14'($urandom), x1});
      csr_write(aec_pkg::CSR_BEZ_Y1, {14'($urandom), y1});
      csr_write(aec_pkg::CSR_BEZ_X2, {14'($urandom), x2});
      csr_write(aec_pkg::CSR_BEZ_Y2, {14'($urandom), y2});
      if ($urandom_range(0, 3) == 0) csr_write(CSR_UNUSED, $urandom);
      csr_we <= 1'b0;
   endtask

   // offer one item, optionally after a random gap, and log its result
   task automatic send_tick(logic [aec_pkg::DELTA_W-1:0] delta, logic restart);
      aec_pkg::req_type it;
      int gap;
      it.delta_us = delta;
      it.restart = restart;
      gap = no_gaps ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      eased_q.push_back(predict_tick(it));
   endtask

   function automatic logic [aec_pkg::CP_W-1:0] rand_cp();
      case ($urandom_range(0, 5))
         0: return 18'h20000;
         1: return 18'h1FFFF;
         2: return 18'($urandom_range(0, 65536));
         default: return 18'($urandom);
      endcase
   endfunction

   // one tick per curve code, bezier endpoints and zero duration
   task automatic test_curves();
      for (int m = 0; m < 16; m++) begin
         configure(1000, m[aec_pkg::MODE_W-1:0], 18'h0C000, 18'h2A000, 18'h06000, 18'h14000);
         send_tick(aec_pkg::DELTA_W'($urandom_range(1, 999)), 1'b1);
      end
      send_tick(20'd0, 1'b1);
      send_tick(20'hFFFFF, 1'b0);
      configure(0, aec_pkg::CURVE_BEZIER, 18'h20000, 18'h1FFFF, 18'h1FFFF, 18'h20000);
      send_tick(20'h5A5A5, 1'b0);
      send_tick(20'd0, 1'b1);
   endtask

   // long run of maximum steps that passes a large duration
   task automatic test_long_run();
      configure(32'h1200_0000, aec_pkg::CURVE_LINEAR, 18'd0, 18'd0, 18'h10000, 18'h10000);
      no_gaps = 1;
      send_tick(20'hFFFFF, 1'b1);
      for (int i = 0; i < 300; i++) send_tick(20'hFFFFF, 1'b0);
      no_gaps = 0;
      send_tick(20'h00001, 1'b0);
      send_tick(20'h00000, 1'b1);
   endtask

   // receiver holds off while items keep coming
   task automatic test_backpressure();
      configure(5000, aec_pkg::CURVE_SMOOTH, 18'd0, 18'd0, 18'h10000, 18'h10000);
      rsp_hold = 400;
      no_gaps = 1;
      for (int i = 0; i < 30; i++)
         send_tick(aec_pkg::DELTA_W'($urandom_range(0, 300)), i == 0);
      no_gaps = 0;
   endtask

   // random settings, each followed by a swept animation
   task automatic test_random();
      logic [31:0] dur;
      int sent, n, mode;
      logic [aec_pkg::DELTA_W-1:0] delta;
      sent = 0;
      while (sent < 450) begin
         case ($urandom_range(0, 7))
            0: dur = 0;
            1: dur = 1;
            2: dur = 32'hFFFF_FFFF;
            3: dur = $urandom;
            default: dur = $urandom_range(1, 2000000);
         endcase
         mode = $urandom_range(0, 15);
         configure(dur, mode[aec_pkg::MODE_W-1:0], rand_cp(), rand_cp(), rand_cp(), rand_cp());
         no_gaps = $urandom_range(0, 4) == 0;
         n = $urandom_range(10, 50);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 5) == 0 || dur == 0) delta = aec_pkg::DELTA_W'($urandom);
            else delta = aec_pkg::DELTA_W'(dur / $urandom_range(4, 40) + $urandom_range(0, 3));
            send_tick(delta, i == 0 || $urandom_range(0, 15) == 0);
         end
         sent += n;
         no_gaps = 0;
      end
   endtask

   // receiver with random stalls and the occasional long hold
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (rsp_hold > 0) begin
            gap = rsp_hold;
            rsp_hold = 0;
         end else gap = no_gaps ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // compare each result with the oldest expectation
   always @(posedge clock) begin
      aec_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (eased_q.size() == 0) begin
            errors++;
            $display("unexpected result at cycle %0d", cycles);
         end else begin
            want = eased_q.pop_front();
            if (rsp_data.alpha !== want.alpha)
               report("alpha", rsp_data.alpha, want.alpha);
            if (rsp_data.progress_q16 !== want.progress_q16)
               report("progress", rsp_data.progress_q16, want.progress_q16);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // test sequence
   initial begin
      elapsed_shadow = 0;
      duration_shadow = 0;
      curve_shadow = aec_pkg::CURVE_LINEAR;
      ctrl_x1 = 0;
      ctrl_y1 = 0;
      ctrl_x2 = Q_ONE;
      ctrl_y2 = Q_ONE;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_curves();
      test_long_run();
      test_backpressure();
      test_random();
      drain();
      repeat (100) @(posedge clock);
      if (errors == 0 && eased_q.size() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// File: animation_easing_curve.f
+incdir+hw/rtl
hw/rtl/aec_pkg.sv
hw/rtl/aec_mul.sv
hw/rtl/aec_div.sv
hw/rtl/aec_seq.sv
hw/rtl/animation_easing_curve.sv
tb/animation_easing_curve_tb.sv
